FILE: design/xcdpr_pkg.sv
`timescale 1ns / 1ps

package xcdpr_pkg;

    localparam int BYTE_W             = 8;
    localparam int STATUS_W           = 3;
    localparam int INDEX_W            = 8;
    localparam int APB_DATA_W         = 32;
    localparam int APB_ADDR_W         = 3;

    // head byte plus three prefix bytes come before the payload
    localparam int HDR_LEN            = 4;
    localparam int DEF_PAYLOAD_LENGTH = 193;

    localparam logic [BYTE_W-1:0] HEAD_RESET = 8'hF5;
    localparam logic [BYTE_W-1:0] TAIL_RESET = 8'hF5;

    typedef enum logic [0:0] {
        REG_HEAD = 1'b0,
        REG_TAIL = 1'b1
    } t_reg_idx;

    typedef enum logic [STATUS_W-1:0] {
        ST_ACCEPT   = 3'd0,
        ST_PAYLOAD  = 3'd1,
        ST_OK       = 3'd2,
        ST_BAD_HEAD = 3'd3,
        ST_BAD_SUM  = 3'd4,
        ST_BAD_TAIL = 3'd5,
        ST_TIMEOUT  = 3'd6
    } t_status;

    typedef struct packed {
        logic [BYTE_W-1:0] head;
        logic [BYTE_W-1:0] tail;
    } t_cfg;

    typedef struct packed {
        t_status            status;
        logic [BYTE_W-1:0]  payload_byte;
        logic [INDEX_W-1:0] payload_index;
    } t_result;

endpackage

FILE: design/xor_checked_data_packet_receiver.sv
`timescale 1ns / 1ps

// Channel  | Direction | Handshake                 | Payload
// ---------+-----------+---------------------------+-----------------------------------------
// in       | input     | i_in_valid / o_in_ready   | i_req_type, i_rx_byte
// out      | output    | o_out_valid / i_out_ready | o_status, o_payload_byte, o_payload_index
// config   | input     | APB psel/penable/pready   | paddr, pwdata, prdata (head, tail)
//
// One byte transfer is taken per cycle while o_in_ready is high; its result shows on the out channel in the next cycle.
// The rate is set by the single result register: a new byte enters whenever that register
// is empty or its result is being taken in the same cycle.
// A stalled out channel holds the result and drops o_in_ready until the result leaves.
// Reset (i_rst_n low at a clock edge) clears the frame position, the running XOR and the
// result valid flag, and loads 0xF5 into both the head and the tail register.

module xor_checked_data_packet_receiver #(
    parameter int PAYLOAD_LENGTH = xcdpr_pkg::DEF_PAYLOAD_LENGTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input byte channel
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_req_type,
    input  logic [xcdpr_pkg::BYTE_W-1:0]        i_rx_byte,
    // result channel
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [xcdpr_pkg::STATUS_W-1:0]      o_status,
    output logic [xcdpr_pkg::BYTE_W-1:0]        o_payload_byte,
    output logic [xcdpr_pkg::INDEX_W-1:0]       o_payload_index,
    // configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [xcdpr_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [xcdpr_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [xcdpr_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                pready
);

    xcdpr_pkg::t_cfg    w_cfg;
    xcdpr_pkg::t_result w_next;
    xcdpr_pkg::t_result w_held;
    logic               w_free;
    logic               w_accept;

    // a byte transfer completes whenever the result register can take its result
    assign o_in_ready = w_free;
    assign w_accept   = i_in_valid && w_free;

    // head and tail match values
    xcdpr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // frame position, running XOR and the per-byte decision
    xcdpr_core #(
        .PAYLOAD_LENGTH (PAYLOAD_LENGTH)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_accept),
        .i_req_type (i_req_type),
        .i_rx_byte  (i_rx_byte),
        .i_cfg      (w_cfg),
        .o_result   (w_next)
    );

    // result register toward the consumer
    xcdpr_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_accept),
        .i_result    (w_next),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_free      (w_free),
        .o_result    (w_held)
    );

    assign o_status        = w_held.status;
    assign o_payload_byte  = w_held.payload_byte;
    assign o_payload_index = w_held.payload_index;

    // an abort transfer always yields a timeout result in the next cycle
    a_abort_reports_timeout: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && i_req_type |=> o_out_valid && (o_status == xcdpr_pkg::ST_TIMEOUT))
        else $error("abort did not report timeout");

    // a received byte never reports a timeout
    a_byte_not_timeout: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && !i_req_type |=> o_status != xcdpr_pkg::ST_TIMEOUT)
        else $error("received byte reported timeout");

    // payload fields are zero outside payload results
    a_payload_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != xcdpr_pkg::ST_PAYLOAD)
        |-> (o_payload_byte == '0) && (o_payload_index == '0))
        else $error("payload fields set on non-payload result");

    // a transfer into a free register always shows a result next cycle
    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_out_valid)
        else $error("accepted byte produced no result");

endmodule

FILE: design/xcdpr_cfg.sv
`timescale 1ns / 1ps

module xcdpr_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [xcdpr_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [xcdpr_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [xcdpr_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                pready,
    output xcdpr_pkg::t_cfg                     o_cfg
);

    logic [xcdpr_pkg::BYTE_W-1:0] r_head;
    logic [xcdpr_pkg::BYTE_W-1:0] r_tail;
    xcdpr_pkg::t_reg_idx          w_idx;
    logic                         w_wr;

    assign pready = 1'b1;
    assign w_idx  = xcdpr_pkg::t_reg_idx'(paddr[2]);
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= xcdpr_pkg::HEAD_RESET;
            r_tail <= xcdpr_pkg::TAIL_RESET;
        end else if (w_wr) begin
            unique case (w_idx)
                xcdpr_pkg::REG_HEAD: r_head <= pwdata[xcdpr_pkg::BYTE_W-1:0];
                xcdpr_pkg::REG_TAIL: r_tail <= pwdata[xcdpr_pkg::BYTE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            xcdpr_pkg::REG_HEAD: prdata = xcdpr_pkg::APB_DATA_W'(r_head);
            xcdpr_pkg::REG_TAIL: prdata = xcdpr_pkg::APB_DATA_W'(r_tail);
            default:             prdata = '0;
        endcase
    end

    assign o_cfg.head = r_head;
    assign o_cfg.tail = r_tail;

endmodule

FILE: design/xcdpr_core.sv
`timescale 1ns / 1ps

module xcdpr_core #(
    parameter int PAYLOAD_LENGTH = xcdpr_pkg::DEF_PAYLOAD_LENGTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic                          i_req_type,
    input  logic [xcdpr_pkg::BYTE_W-1:0]  i_rx_byte,
    input  xcdpr_pkg::t_cfg               i_cfg,
    output xcdpr_pkg::t_result            o_result
);

    localparam int POS_W = $clog2(PAYLOAD_LENGTH + 6);
    // keep at least index width so the payload index is a plain part-select
    localparam int CNT_W = (POS_W > xcdpr_pkg::INDEX_W) ? POS_W : xcdpr_pkg::INDEX_W;

    localparam logic [CNT_W-1:0] LAST_PREFIX = CNT_W'(xcdpr_pkg::HDR_LEN - 1);
    localparam logic [CNT_W-1:0] FIRST_PAY   = CNT_W'(xcdpr_pkg::HDR_LEN);
    localparam logic [CNT_W-1:0] LAST_PAY    = CNT_W'(PAYLOAD_LENGTH + xcdpr_pkg::HDR_LEN - 1);
    localparam logic [CNT_W-1:0] SUM_POS     = CNT_W'(PAYLOAD_LENGTH + xcdpr_pkg::HDR_LEN);

    logic [CNT_W-1:0]              r_pos;
    logic [CNT_W-1:0]              n_pos;
    logic [xcdpr_pkg::BYTE_W-1:0]  r_xor;
    logic [xcdpr_pkg::BYTE_W-1:0]  n_xor;
    logic [CNT_W-1:0]              w_off;

    assign w_off = r_pos - FIRST_PAY;

    always_comb begin
        n_pos                  = r_pos;
        n_xor                  = r_xor;
        o_result.status        = xcdpr_pkg::ST_ACCEPT;
        o_result.payload_byte  = '0;
        o_result.payload_index = '0;
        if (i_req_type) begin
            o_result.status = xcdpr_pkg::ST_TIMEOUT;
            n_pos           = '0;
            n_xor           = '0;
        end else if (r_pos == '0) begin
            if (i_rx_byte != i_cfg.head) begin
                o_result.status = xcdpr_pkg::ST_BAD_HEAD;
            end else begin
                n_pos = r_pos + CNT_W'(1);
            end
        end else if (r_pos <= LAST_PREFIX) begin
            n_xor = r_xor ^ i_rx_byte;
            n_pos = r_pos + CNT_W'(1);
        end else if (r_pos <= LAST_PAY) begin
            n_xor                  = r_xor ^ i_rx_byte;
            n_pos                  = r_pos + CNT_W'(1);
            o_result.status        = xcdpr_pkg::ST_PAYLOAD;
            o_result.payload_byte  = i_rx_byte;
            o_result.payload_index = w_off[xcdpr_pkg::INDEX_W-1:0];
        end else if (r_pos == SUM_POS) begin
            if (i_rx_byte != r_xor) begin
                o_result.status = xcdpr_pkg::ST_BAD_SUM;
                n_pos           = '0;
                n_xor           = '0;
            end else begin
                n_pos = r_pos + CNT_W'(1);
            end
        end else begin
            o_result.status = (i_rx_byte == i_cfg.tail) ? xcdpr_pkg::ST_OK
                                                        : xcdpr_pkg::ST_BAD_TAIL;
            n_pos           = '0;
            n_xor           = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_xor <= '0;
        end else if (i_accept) begin
            r_pos <= n_pos;
            r_xor <= n_xor;
        end
    end

endmodule

FILE: design/xcdpr_out.sv
`timescale 1ns / 1ps

module xcdpr_out (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  xcdpr_pkg::t_result  i_result,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output logic                o_free,
    output xcdpr_pkg::t_result  o_result
);

    logic               r_valid;
    xcdpr_pkg::t_result r_result;

    // free when empty or when the held result leaves this cycle
    assign o_free = !r_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_out_valid = r_valid;
    assign o_result    = r_result;

endmodule

FILE: tb/xcdpr_checker.sv
`timescale 1ns / 1ps

module xcdpr_checker #(
    parameter int PAYLOAD_LENGTH = xcdpr_pkg::DEF_PAYLOAD_LENGTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                i_in_ready,
    input  logic                                i_req_type,
    input  logic [xcdpr_pkg::BYTE_W-1:0]        i_rx_byte,
    input  logic                                i_out_valid,
    input  logic                                i_out_ready,
    input  logic [xcdpr_pkg::STATUS_W-1:0]      i_status,
    input  logic [xcdpr_pkg::BYTE_W-1:0]        i_payload_byte,
    input  logic [xcdpr_pkg::INDEX_W-1:0]       i_payload_index,
    input  logic                                i_psel,
    input  logic                                i_penable,
    input  logic                                i_pwrite,
    input  logic [xcdpr_pkg::APB_ADDR_W-1:0]    i_paddr,
    input  logic [xcdpr_pkg::APB_DATA_W-1:0]    i_pwdata,
    input  logic [xcdpr_pkg::APB_DATA_W-1:0]    i_prdata,
    input  logic                                i_pready,
    output int                                  o_fail_cnt,
    output int                                  o_pending
);

    logic [xcdpr_pkg::BYTE_W-1:0]     head_cfg;
    logic [xcdpr_pkg::BYTE_W-1:0]     tail_cfg;
    int unsigned                      frame_pos;
    logic [xcdpr_pkg::BYTE_W-1:0]     sum_acc;
    xcdpr_pkg::t_result               pending_results[$];
    xcdpr_pkg::t_result               want;
    logic [xcdpr_pkg::BYTE_W-1:0]     rd_want;
    int                               mismatches = 0;

    function automatic void clear_frame();
        frame_pos = 0;
        sum_acc   = '0;
    endfunction

    // One byte transfer in, one status out; frame_pos counts bytes of the current frame.
    function automatic xcdpr_pkg::t_result deframe_step(logic abort,
                                                        logic [xcdpr_pkg::BYTE_W-1:0] b);
        xcdpr_pkg::t_result r;
        int unsigned        pos;
        r.status        = xcdpr_pkg::ST_ACCEPT;
        r.payload_byte  = '0;
        r.payload_index = '0;
        pos = frame_pos + 1;
        if (abort) begin
            r.status = xcdpr_pkg::ST_TIMEOUT;
            clear_frame();
        end else if (pos == 1) begin
            if (b != head_cfg) begin
                r.status = xcdpr_pkg::ST_BAD_HEAD;
                clear_frame();
            end else begin
                frame_pos = pos;
            end
        end else if (pos <= xcdpr_pkg::HDR_LEN) begin
            sum_acc  ^= b;
            frame_pos = pos;
        end else if (pos <= PAYLOAD_LENGTH + xcdpr_pkg::HDR_LEN) begin
            sum_acc        ^= b;
            r.status        = xcdpr_pkg::ST_PAYLOAD;
            r.payload_byte  = b;
            // index wraps at 256 with the 8-bit field
            r.payload_index = xcdpr_pkg::INDEX_W'(pos - xcdpr_pkg::HDR_LEN - 1);
            frame_pos       = pos;
        end else if (pos == PAYLOAD_LENGTH + xcdpr_pkg::HDR_LEN + 1) begin
            if (b != sum_acc) begin
                r.status = xcdpr_pkg::ST_BAD_SUM;
                clear_frame();
            end else begin
                frame_pos = pos;
            end
        end else begin
            r.status = (b == tail_cfg) ? xcdpr_pkg::ST_OK : xcdpr_pkg::ST_BAD_TAIL;
            clear_frame();
        end
        return r;
    endfunction

    task automatic flag(string msg);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%0t ns mismatch: %s", $time, msg);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            head_cfg = xcdpr_pkg::HEAD_RESET;
            tail_cfg = xcdpr_pkg::TAIL_RESET;
            clear_frame();
            pending_results.delete();
        end else begin
            // retire the result first; an input taken at this edge cannot answer here
            if (i_out_valid && i_out_ready) begin
                if (pending_results.size() == 0) begin
                    flag($sformatf("unexpected result: status %0d byte %02h index %0d",
                                   i_status, i_payload_byte, i_payload_index));
                end else begin
                    want = pending_results.pop_front();
                    if (i_status !== want.status || i_payload_byte !== want.payload_byte ||
                        i_payload_index !== want.payload_index) begin
                        flag($sformatf({"expected status %0d byte %02h index %0d, ",
                                        "got status %0d byte %02h index %0d"},
                                       want.status, want.payload_byte, want.payload_index,
                                       i_status, i_payload_byte, i_payload_index));
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                pending_results.push_back(deframe_step(i_req_type, i_rx_byte));
            end
            if (i_psel && i_penable && i_pready) begin
                if (i_pwrite) begin
                    case (xcdpr_pkg::t_reg_idx'(i_paddr[2]))
                        xcdpr_pkg::REG_HEAD: head_cfg = i_pwdata[xcdpr_pkg::BYTE_W-1:0];
                        xcdpr_pkg::REG_TAIL: tail_cfg = i_pwdata[xcdpr_pkg::BYTE_W-1:0];
                    endcase
                end else begin
                    rd_want = (xcdpr_pkg::t_reg_idx'(i_paddr[2]) == xcdpr_pkg::REG_TAIL)
                              ? tail_cfg : head_cfg;
                    if (i_prdata !== xcdpr_pkg::APB_DATA_W'(rd_want)) begin
                        flag($sformatf("register read at %0d: expected %08h, got %08h",
                                       i_paddr, xcdpr_pkg::APB_DATA_W'(rd_want), i_prdata));
                    end
                end
            end
        end
        o_pending  <= pending_results.size();
        o_fail_cnt <= mismatches;
    end

endmodule

FILE: tb/tb_xor_checked_data_packet_receiver.sv
`timescale 1ns / 1ps

module tb_xor_checked_data_packet_receiver;

    localparam int PAYLOAD_LEN = xcdpr_pkg::DEF_PAYLOAD_LENGTH;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_ITEMS = 140;
    // long receiver hold-off: starts once this many transfers went in
    localparam int HOLD_AFTER  = 300;
    localparam int HOLD_CYCLES = 150;

    logic                                i_clk;
    logic                                i_rst_n;
    logic                                i_in_valid;
    logic                                o_in_ready;
    logic                                i_req_type;
    logic [xcdpr_pkg::BYTE_W-1:0]        i_rx_byte;
    logic                                o_out_valid;
    logic                                i_out_ready;
    logic [xcdpr_pkg::STATUS_W-1:0]      o_status;
    logic [xcdpr_pkg::BYTE_W-1:0]        o_payload_byte;
    logic [xcdpr_pkg::INDEX_W-1:0]       o_payload_index;
    logic                                psel;
    logic                                penable;
    logic                                pwrite;
    logic [xcdpr_pkg::APB_ADDR_W-1:0]    paddr;
    logic [xcdpr_pkg::APB_DATA_W-1:0]    pwdata;
    logic [xcdpr_pkg::APB_DATA_W-1:0]    prdata;
    logic                                pready;

    int                                  fail_cnt;
    int                                  pending;
    int                                  sent_cnt  = 0;
    int                                  cycles    = 0;
    int                                  idle_pct  = 0;
    bit                                  quiet     = 0;
    bit                                  hold_done = 0;
    logic [xcdpr_pkg::BYTE_W-1:0]        cur_head  = xcdpr_pkg::HEAD_RESET;
    logic [xcdpr_pkg::BYTE_W-1:0]        cur_tail  = xcdpr_pkg::TAIL_RESET;

    xor_checked_data_packet_receiver #(
        .PAYLOAD_LENGTH (PAYLOAD_LEN)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_req_type      (i_req_type),
        .i_rx_byte       (i_rx_byte),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_status        (o_status),
        .o_payload_byte  (o_payload_byte),
        .o_payload_index (o_payload_index),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    xcdpr_checker #(
        .PAYLOAD_LENGTH (PAYLOAD_LEN)
    ) u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_ready      (o_in_ready),
        .i_req_type      (i_req_type),
        .i_rx_byte       (i_rx_byte),
        .i_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .i_status        (o_status),
        .i_payload_byte  (o_payload_byte),
        .i_payload_index (o_payload_index),
        .i_psel          (psel),
        .i_penable       (penable),
        .i_pwrite        (pwrite),
        .i_paddr         (paddr),
        .i_pwdata        (pwdata),
        .i_prdata        (prdata),
        .i_pready        (pready),
        .o_fail_cnt      (fail_cnt),
        .o_pending       (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: stop a hung run at a hard cycle limit.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("xor_checked_data_packet_receiver test failed");
            $finish;
        end
    end

    // Skew bytes toward the all-zero and all-one corners now and then.
    function automatic logic [xcdpr_pkg::BYTE_W-1:0] rand_byte();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // Offer one byte transfer; sometimes insert a random gap first, then hold it until taken.
    task automatic offer_byte(logic abort, logic [xcdpr_pkg::BYTE_W-1:0] b);
        int gap;
        if (!quiet && idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
            gap = $urandom_range(1, 18);
            @(negedge i_clk);
            i_in_valid = 1'b0;
            i_req_type = 1'($urandom);
            i_rx_byte  = 8'($urandom);
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid = 1'b1;
        i_req_type = abort;
        i_rx_byte  = b;
        do @(posedge i_clk); while (!o_in_ready);
        sent_cnt++;
    endtask

    // Send a complete frame; optionally corrupt the checksum or the tail.
    task automatic send_frame(bit bad_sum, bit bad_tail);
        logic [xcdpr_pkg::BYTE_W-1:0] acc;
        logic [xcdpr_pkg::BYTE_W-1:0] b;
        acc = '0;
        offer_byte(1'b0, cur_head);
        for (int k = 0; k < PAYLOAD_LEN + xcdpr_pkg::HDR_LEN - 1; k++) begin
            b    = rand_byte();
            acc ^= b;
            offer_byte(1'b0, b);
        end
        if (bad_sum) begin
            offer_byte(1'b0, acc ^ 8'($urandom_range(1, 255)));
        end else begin
            offer_byte(1'b0, acc);
            offer_byte(1'b0, bad_tail ? cur_tail ^ 8'($urandom_range(1, 255)) : cur_tail);
        end
    endtask

    // Start a frame, cut it anywhere up to the wait for the tail, then abort.
    task automatic send_cut_frame();
        logic [xcdpr_pkg::BYTE_W-1:0] acc;
        logic [xcdpr_pkg::BYTE_W-1:0] b;
        int                           cut;
        acc = '0;
        cut = $urandom_range(0, 1) ? $urandom_range(0, 8)
                                   : $urandom_range(0, PAYLOAD_LEN + xcdpr_pkg::HDR_LEN);
        offer_byte(1'b0, cur_head);
        for (int k = 0; k < cut; k++) begin
            if (k == PAYLOAD_LEN + xcdpr_pkg::HDR_LEN - 1) begin
                // checksum slot: send it right so the abort lands while awaiting the tail
                offer_byte(1'b0, acc);
            end else begin
                b    = rand_byte();
                acc ^= b;
                offer_byte(1'b0, b);
            end
        end
        offer_byte(1'b1, rand_byte());
    endtask

    // Line noise, then an abort to bring the frame logic back to idle.
    task automatic send_noise();
        int n;
        n = $urandom_range(1, 5);
        repeat (n) offer_byte(1'b0, rand_byte());
        offer_byte(1'b1, rand_byte());
    endtask

    // One APB transfer: setup cycle, then access cycle until pready.
    task automatic apb_access(bit wr, xcdpr_pkg::t_reg_idx r,
                              logic [xcdpr_pkg::BYTE_W-1:0] v);
        @(negedge i_clk);
        psel       = 1'b1;
        penable    = 1'b0;
        pwrite     = wr;
        paddr      = xcdpr_pkg::APB_ADDR_W'({r, 2'b00});
        pwdata     = $urandom;
        pwdata[xcdpr_pkg::BYTE_W-1:0] = v;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic set_config(logic [xcdpr_pkg::BYTE_W-1:0] h,
                              logic [xcdpr_pkg::BYTE_W-1:0] t);
        apb_access(1'b1, xcdpr_pkg::REG_HEAD, h);
        apb_access(1'b1, xcdpr_pkg::REG_TAIL, t);
        apb_access(1'b0, xcdpr_pkg::REG_HEAD, 8'h00);
        apb_access(1'b0, xcdpr_pkg::REG_TAIL, 8'h00);
        cur_head = h;
        cur_tail = t;
    endtask

    // Drop valid and wait until every expected status has come out.
    task automatic drain();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (2) @(negedge i_clk);
    endtask

    // Mostly full frames, half with a bad sum or tail; else cut frames, noise, lone aborts.
    task automatic run_phase(int quota);
        int first;
        int pick;
        int outcome;
        first = sent_cnt;
        while (sent_cnt - first < quota) begin
            case ($urandom_range(0, 2))
                0:       idle_pct = 0;
                1:       idle_pct = 8;
                default: idle_pct = 35;
            endcase
            pick = $urandom_range(0, 99);
            if (pick < 62) begin
                outcome = $urandom_range(0, 3);
                send_frame(outcome == 2, outcome == 3);
            end else if (pick < 80) begin
                send_cut_frame();
            end else if (pick < 93) begin
                send_noise();
            end else begin
                offer_byte(1'b1, rand_byte());
            end
        end
    endtask

    // Result side: random stall bursts, one long hold-off, none in the final phase.
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!hold_done && !quiet && sent_cnt >= HOLD_AFTER && i_in_valid) begin
                // hold off long enough for the block to fill and drop o_in_ready
                i_out_ready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                hold_done = 1'b1;
            end else if (!quiet && $urandom_range(0, 99) < 15) begin
                i_out_ready = 1'b0;
                repeat ($urandom_range(0, 17)) @(negedge i_clk);
            end else begin
                i_out_ready = 1'b1;
                repeat ($urandom_range(0, 29)) @(negedge i_clk);
            end
        end
    end

    initial begin
        logic [xcdpr_pkg::BYTE_W-1:0] body [6] = '{8'h00, 8'hFF, 8'h5A, 8'h00, 8'hFF, 8'hA5};

        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_req_type = 1'b0;
        i_rx_byte  = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Read back the reset values of both registers.
        apb_access(1'b0, xcdpr_pkg::REG_HEAD, 8'h00);
        apb_access(1'b0, xcdpr_pkg::REG_TAIL, 8'h00);

        // Directed: abort while idle, wrong heads, aborts right after the head and
        // inside the payload, and a wrong head followed at once by a good one.
        idle_pct = 20;
        offer_byte(1'b1, 8'hFF);
        offer_byte(1'b0, 8'h00);
        offer_byte(1'b0, 8'hFF);
        offer_byte(1'b0, cur_head);
        offer_byte(1'b1, 8'h00);
        offer_byte(1'b0, cur_head);
        foreach (body[k]) offer_byte(1'b0, body[k]);
        offer_byte(1'b1, 8'h5A);
        offer_byte(1'b0, cur_head ^ 8'h01);
        offer_byte(1'b0, cur_head);
        offer_byte(1'b1, 8'hA5);

        run_phase(PHASE_ITEMS);

        // Walk the register extremes, then a random setting with no idling at all.
        drain();
        set_config(8'h00, 8'hFF);
        run_phase(PHASE_ITEMS);

        drain();
        set_config(8'hFF, 8'h00);
        run_phase(PHASE_ITEMS);

        drain();
        set_config(8'($urandom), 8'($urandom));
        quiet = 1'b1;
        run_phase(PHASE_ITEMS);

        drain();
        repeat (4) @(negedge i_clk);
        if (fail_cnt == 0 && pending == 0) begin
            $display("xor_checked_data_packet_receiver test passed");
        end else begin
            $display("xor_checked_data_packet_receiver test failed");
        end
        $finish;
    end

endmodule
